>>> src/jsu_pkg.sv
package jsu_pkg;

	// decoder modes; values outside the list behave as idle
	typedef enum logic [3:0] {
		MODE_IDLE   = 4'd0,
		MODE_BODY   = 4'd1,
		MODE_ESC    = 4'd2,
		MODE_HEX0   = 4'd3,
		MODE_HEX1   = 4'd4,
		MODE_HEX2   = 4'd5,
		MODE_HEX3   = 4'd6,
		MODE_SUR_BS = 4'd7,
		MODE_SUR_U  = 4'd8,
		MODE_LO0    = 4'd9,
		MODE_LO1    = 4'd10,
		MODE_LO2    = 4'd11,
		MODE_LO3    = 4'd12
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_CONT  = 2'd0,
		ST_CLOSE = 2'd1,
		ST_ERR   = 2'd2
	} status_t;

	// byte codes used by the decoder
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;

	localparam int JSU_QUEUE_DEPTH = 4;
	localparam int JSU_MAX_BYTES = 4;

	// one decoded input word: up to four utf-8 bytes, or a lone status result
	typedef struct packed {
		logic [JSU_MAX_BYTES-1:0][7:0] data;
		logic [2:0]                    nbytes;
		status_t                       status;
	} jsu_entry_t;

endpackage

>>> src/jsu_front.sv
module jsu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic               end_of_text,
	output jsu_pkg::jsu_entry_t entry
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_d;
	logic [15:0] cu_q, cu_d;
	logic [9:0]  hs_q, hs_d;
	logic [3:0]  hex_val;
	logic        hex_ok;
	logic [15:0] cu_shift;
	logic [20:0] cp;
	logic        do_utf8;
	logic [10:0] hs_plus;

	// hex digit of either case
	always_comb begin
		hex_ok = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
		             (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign cu_shift = {cu_q[11:0], hex_val};
	assign hs_plus = {1'b0, hs_q} + 11'd64;

	// next mode and classification of the current word
	always_comb begin
		mode_d = mode_q;
		cu_d = cu_q;
		hs_d = hs_q;
		entry.status = ST_CONT;
		entry.nbytes = 3'd0;
		entry.data = '0;
		cp = 21'd0;
		do_utf8 = 1'b0;
		if (end_of_text) begin
			entry.status = ST_ERR;
		end else begin
			unique case (mode_q)
				MODE_BODY: begin
					if (in_byte == CH_QUOTE) begin
						entry.status = ST_CLOSE;
					end else if (in_byte == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						entry.nbytes = 3'd1;
						entry.data[0] = in_byte;
					end
				end
				MODE_ESC: begin
					mode_d = MODE_BODY;
					entry.nbytes = 3'd1;
					case (in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: entry.data[0] = in_byte;
						CH_B: entry.data[0] = 8'h08;
						CH_F: entry.data[0] = 8'h0C;
						CH_N: entry.data[0] = 8'h0A;
						CH_R: entry.data[0] = 8'h0D;
						CH_T: entry.data[0] = 8'h09;
						CH_U: begin
							entry.nbytes = 3'd0;
							cu_d = 16'd0;
							mode_d = MODE_HEX0;
						end
						default: begin
							entry.nbytes = 3'd0;
							entry.status = ST_ERR;
						end
					endcase
				end
				MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
					if (!hex_ok) begin
						entry.status = ST_ERR;
					end else begin
						cu_d = cu_shift;
						if (mode_q != MODE_HEX3) begin
							mode_d = mode_t'(mode_q + 4'd1);
						end else if (cu_shift[15:10] == 6'b110110) begin
							// high surrogate: wait for the low half
							hs_d = cu_shift[9:0];
							mode_d = MODE_SUR_BS;
						end else begin
							cp = {5'd0, cu_shift};
							do_utf8 = 1'b1;
							mode_d = MODE_BODY;
						end
					end
				end
				MODE_SUR_BS: begin
					if (in_byte == CH_BSLASH) mode_d = MODE_SUR_U;
					else entry.status = ST_ERR;
				end
				MODE_SUR_U: begin
					if (in_byte == CH_U) begin
						cu_d = 16'd0;
						mode_d = MODE_LO0;
					end else begin
						entry.status = ST_ERR;
					end
				end
				MODE_LO0, MODE_LO1, MODE_LO2, MODE_LO3: begin
					if (!hex_ok) begin
						entry.status = ST_ERR;
					end else begin
						cu_d = cu_shift;
						if (mode_q != MODE_LO3) begin
							mode_d = mode_t'(mode_q + 4'd1);
						end else if (cu_shift[15:10] != 6'b110111) begin
							entry.status = ST_ERR;
						end else begin
							cp = {hs_plus, cu_shift[9:0]};
							do_utf8 = 1'b1;
							mode_d = MODE_BODY;
						end
					end
				end
				default: begin
					if (in_byte == CH_QUOTE) mode_d = MODE_BODY;
					else entry.status = ST_ERR;
				end
			endcase
		end
		if (entry.status != ST_CONT) mode_d = MODE_IDLE;

		// utf-8 encoding of the code point
		if (do_utf8) begin
			if (cp < 21'h80) begin
				entry.nbytes = 3'd1;
				entry.data[0] = cp[7:0];
			end else if (cp < 21'h800) begin
				entry.nbytes = 3'd2;
				entry.data[0] = {3'b110, cp[10:6]};
				entry.data[1] = {2'b10, cp[5:0]};
			end else if (cp < 21'h10000) begin
				entry.nbytes = 3'd3;
				entry.data[0] = {4'b1110, cp[15:12]};
				entry.data[1] = {2'b10, cp[11:6]};
				entry.data[2] = {2'b10, cp[5:0]};
			end else begin
				entry.nbytes = 3'd4;
				entry.data[0] = {5'b11110, cp[20:18]};
				entry.data[1] = {2'b10, cp[17:12]};
				entry.data[2] = {2'b10, cp[11:6]};
				entry.data[3] = {2'b10, cp[5:0]};
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cu_q <= 16'd0;
			hs_q <= 10'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			cu_q <= cu_d;
			hs_q <= hs_d;
		end
	end

endmodule

>>> src/jsu_queue.sv
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enq,
	input  jsu_pkg::jsu_entry_t enq_entry,
	output logic                full,
	input  logic                deq,
	output logic                head_valid,
	output jsu_pkg::jsu_entry_t head
);
	import jsu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jsu_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (enq) mem_q[wr_ptr_q] <= enq_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) count_q <= count_q + 1'b1;
			else if (!enq && deq) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> src/jsu_back.sv
module jsu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  jsu_pkg::jsu_entry_t head,
	input  logic                pop,
	output logic                deq,
	output logic                empty,
	output logic [7:0]          out_byte,
	output logic                has_byte,
	output logic [1:0]          status,
	output logic                last
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic       take;

	// present one result word of the head entry
	assign empty = !head_valid;
	assign has_byte = (head.nbytes != 3'd0);
	assign out_byte = has_byte ? head.data[idx_q] : 8'd0;
	assign status = head.status;
	assign last = !has_byte || ({1'b0, idx_q} == head.nbytes - 3'd1);
	assign take = pop && head_valid;
	assign deq = take && last;

	// byte index within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

>>> src/json_string_unescape_top.sv
// timing: the decoder is combinational; each taken input word is registered in the queue
// throughput: one input word per cycle unless full, one result word per cycle
//   while pop is high; each utf-8 byte of an escape is its own result word; the
//   decoded-word queue between decoder and serializer sets how far input runs ahead
// reset: arst_n clears the decoder to idle and empties the queue
module json_string_unescape_top #(
	parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic [1:0] status,
	output logic       last
);
	import jsu_pkg::*;

	jsu_entry_t front_entry, head;
	logic       accept, head_valid, deq;

	assign accept = push && !full;

	// decoder
	jsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.entry       (front_entry)
	);

	// decoded-word queue
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.enq        (accept),
		.enq_entry  (front_entry),
		.full       (full),
		.deq        (deq),
		.head_valid (head_valid),
		.head       (head)
	);

	// serializer
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.deq        (deq),
		.empty      (empty),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.status     (status),
		.last       (last)
	);

	// closing or error words stand alone and end their input word
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_CONT) |-> (last && !has_byte))
		else $error("status word not final or carries a byte");

	// a word with no content byte is always the final one
	a_nobyte_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !has_byte) |-> last)
		else $error("empty result word not marked last");

	// a taken input word shows up on the result side
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !empty)
		else $error("accepted word lost");

	// content bytes only come with continuing status
	a_byte_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && has_byte) |-> (status == ST_CONT))
		else $error("content byte with terminal status");

endmodule

>>> bench/json_string_unescape_top_tb.sv
`timescale 1ns / 1ps

module json_string_unescape_top_tb;
	import jsu_pkg::*;

	// one result word as the block presents it
	typedef struct {
		logic [7:0] data;
		logic       has;
		status_t    st;
		logic       lst;
	} utf8_word_t;

	// how a generated string ends
	typedef enum int {
		END_CLOSE,
		END_EOT,
		END_BAD_ESCAPE,
		END_BAD_HEX,
		END_NO_BSLASH,
		END_NO_U,
		END_BAD_LOW,
		END_BAD_LOW_HEX,
		END_EOT_IN_ESCAPE,
		END_IDLE_NOISE,
		END_KINDS
	} ending_t;

	// decoder model and the queue of utf-8 words it still owes
	class utf8_ledger;
		mode_t      mode;
		logic [15:0] unit;
		logic [9:0]  hi_bits;
		utf8_word_t  words[$];
		int          fails;

		function new();
			mode = MODE_IDLE;
			unit = '0;
			hi_bits = '0;
			fails = 0;
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
			if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
			if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
			return -1;
		endfunction

		function void add_byte(logic [7:0] b);
			utf8_word_t w;
			w.data = b;
			w.has = 1'b1;
			w.st = ST_CONT;
			w.lst = 1'b0;
			words.push_back(w);
		endfunction

		// code point to 1..4 utf-8 bytes
		function void add_utf8(logic [20:0] cp);
			if (cp < 21'h80) begin
				add_byte(cp[7:0]);
			end else if (cp < 21'h800) begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end else if (cp < 21'h10000) begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end else begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endfunction

		// advance the decoder by one accepted input word
		function void note_input(logic [7:0] b, logic eot);
			status_t    st;
			int         first;
			int         d;
			utf8_word_t w;
			st = ST_CONT;
			first = words.size();
			if (eot) begin
				st = ST_ERR;
			end else if (mode == MODE_BODY) begin
				if (b == CH_QUOTE) st = ST_CLOSE;
				else if (b == CH_BSLASH) mode = MODE_ESC;
				else add_byte(b);
			end else if (mode == MODE_ESC) begin
				mode = MODE_BODY;
				case (b)
					CH_QUOTE, CH_BSLASH, CH_SLASH: add_byte(b);
					CH_B: add_byte(8'h08);
					CH_F: add_byte(8'h0C);
					CH_N: add_byte(8'h0A);
					CH_R: add_byte(8'h0D);
					CH_T: add_byte(8'h09);
					CH_U: begin
						unit = '0;
						mode = MODE_HEX0;
					end
					default: st = ST_ERR;
				endcase
			end else if (mode >= MODE_HEX0 && mode <= MODE_HEX3) begin
				d = hex_nibble(b);
				if (d < 0) begin
					st = ST_ERR;
				end else begin
					unit = {unit[11:0], d[3:0]};
					if (mode != MODE_HEX3) begin
						mode = mode_t'(mode + 4'd1);
					end else if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
						hi_bits = unit[9:0];
						mode = MODE_SUR_BS;
					end else begin
						add_utf8({5'd0, unit});
						mode = MODE_BODY;
					end
				end
			end else if (mode == MODE_SUR_BS) begin
				if (b == CH_BSLASH) mode = MODE_SUR_U;
				else st = ST_ERR;
			end else if (mode == MODE_SUR_U) begin
				if (b == CH_U) begin
					unit = '0;
					mode = MODE_LO0;
				end else begin
					st = ST_ERR;
				end
			end else if (mode >= MODE_LO0 && mode <= MODE_LO3) begin
				d = hex_nibble(b);
				if (d < 0) begin
					st = ST_ERR;
				end else begin
					unit = {unit[11:0], d[3:0]};
					if (mode != MODE_LO3) begin
						mode = mode_t'(mode + 4'd1);
					end else if (unit < 16'hDC00 || unit > 16'hDFFF) begin
						st = ST_ERR;
					end else begin
						add_utf8(21'h10000 + {1'b0, hi_bits, unit[9:0]});
						mode = MODE_BODY;
					end
				end
			end else begin
				// idle and unused modes
				if (b == CH_QUOTE) mode = MODE_BODY;
				else st = ST_ERR;
			end
			if (st != ST_CONT) mode = MODE_IDLE;
			// status-only word when nothing was emitted or the string ended
			if (words.size() == first || st != ST_CONT) begin
				w.data = 8'h00;
				w.has = 1'b0;
				w.st = st;
				w.lst = 1'b0;
				words.push_back(w);
			end
			w = words.pop_back();
			w.lst = 1'b1;
			words.push_back(w);
		endfunction

		// compare one popped word with the oldest owed word
		function void check_word(logic [7:0] ob, logic hb, logic [1:0] st, logic lst);
			utf8_word_t w;
			if (words.size() == 0) begin
				fails++;
				$display("%0t: unexpected word: byte=%h has=%b status=%0d last=%b",
					$time, ob, hb, st, lst);
				return;
			end
			w = words.pop_front();
			if (w.data !== ob || w.has !== hb || w.st !== st || w.lst !== lst) begin
				fails++;
				$display("%0t: mismatch: expected byte=%h has=%b status=%0d last=%b",
					$time, w.data, w.has, w.st, w.lst);
				$display("%0t:           actual   byte=%h has=%b status=%0d last=%b",
					$time, ob, hb, st, lst);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       pop = 1'b0;
	logic       empty;
	logic [7:0] out_byte;
	logic       has_byte;
	logic [1:0] status;
	logic       last;

	utf8_ledger ledger;
	int         burst_left = 0;
	int         gaps_on = 1;
	int         n_sent = 0;
	int         rx_cycles = 0;
	int         pop_pct = 100;
	logic [7:0] short_esc [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	json_string_unescape_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.end_of_text(end_of_text),
		.pop(pop),
		.empty(empty),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.status(status),
		.last(last)
	);

	always #5 clk = ~clk;

	// receiver: check each popped word; the stall rate is redrawn at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) ledger.check_word(out_byte, has_byte, status, last);
			if (rx_cycles % 50 == 0) begin
				case ($urandom_range(0, 3))
					0: pop_pct = 100;
					1: pop_pct = 60;
					2: pop_pct = 25;
					default: pop_pct = 85;
				endcase
			end
			rx_cycles++;
			pop <= ($urandom_range(0, 99) < pop_pct);
		end
	end

	// sender: one word per call, bursts separated by random gaps when gaps_on is set
	task automatic send_word(logic [7:0] b, logic eot);
		if (burst_left == 0) begin
			if (gaps_on != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		push <= 1'b1;
		in_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (full) @(posedge clk);
		ledger.note_input(b, eot);
		n_sent++;
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + nib;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (ledger.hex_nibble(b) >= 0);
		return b;
	endfunction

	task automatic send_hex_escape(logic [15:0] u);
		send_word(CH_BSLASH, 1'b0);
		send_word(CH_U, 1'b0);
		for (int i = 3; i >= 0; i--) send_word(hex_char(u[i*4 +: 4]), 1'b0);
	endtask

	// backslash, u and fewer than four digits
	task automatic send_partial_escape(int k);
		send_word(CH_BSLASH, 1'b0);
		send_word(CH_U, 1'b0);
		for (int i = 0; i < k; i++) send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
	endtask

	// one string with random content, ending as the kind says
	task automatic send_string(ending_t kind);
		int         n_elems;
		logic [15:0] u;
		logic [7:0]  b;
		gaps_on = ($urandom_range(0, 3) != 0);
		send_word(CH_QUOTE, 1'b0);
		n_elems = $urandom_range(0, 5);
		for (int i = 0; i < n_elems; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_QUOTE || b == CH_BSLASH) b ^= 8'h01;
					send_word(b, 1'b0);
				end
				4, 5: begin
					send_word(CH_BSLASH, 1'b0);
					send_word(short_esc[$urandom_range(0, 7)], 1'b0);
				end
				6, 7: begin
					// plain code unit of 1, 2 or 3 utf-8 bytes
					case ($urandom_range(0, 2))
						0: u = 16'($urandom_range(0, 16'h7F));
						1: u = 16'($urandom_range(16'h80, 16'h7FF));
						default: u = 16'($urandom_range(16'h800, 16'hFFFF));
					endcase
					if (u >= 16'hD800 && u <= 16'hDFFF) u ^= 16'h4000;
					send_hex_escape(u);
				end
				8: begin
					send_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
					send_hex_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
				end
				default: send_hex_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
			endcase
		end
		case (kind)
			END_CLOSE: send_word(CH_QUOTE, 1'b0);
			END_EOT: send_word(8'($urandom_range(0, 255)), 1'b1);
			END_BAD_ESCAPE: begin
				send_word(CH_BSLASH, 1'b0);
				do b = 8'($urandom_range(0, 255));
				while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
					b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
				send_word(b, 1'b0);
			end
			END_BAD_HEX: begin
				send_partial_escape($urandom_range(0, 3));
				send_word(non_hex_byte(), 1'b0);
			end
			END_NO_BSLASH: begin
				send_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
				b = 8'($urandom_range(0, 255));
				if (b == CH_BSLASH) b ^= 8'h01;
				send_word(b, 1'b0);
			end
			END_NO_U: begin
				send_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
				send_word(CH_BSLASH, 1'b0);
				b = 8'($urandom_range(0, 255));
				if (b == CH_U) b ^= 8'h01;
				send_word(b, 1'b0);
			end
			END_BAD_LOW: begin
				send_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
				u = 16'($urandom_range(0, 16'hFFFF));
				if (u >= 16'hDC00 && u <= 16'hDFFF) u ^= 16'h8000;
				send_hex_escape(u);
			end
			END_BAD_LOW_HEX: begin
				send_hex_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
				send_partial_escape($urandom_range(0, 3));
				send_word(non_hex_byte(), 1'b0);
			end
			END_EOT_IN_ESCAPE: begin
				send_partial_escape($urandom_range(0, 3));
				send_word(8'($urandom_range(0, 255)), 1'b1);
			end
			default: begin
				// closed string followed by stray bytes while idle
				send_word(CH_QUOTE, 1'b0);
				repeat ($urandom_range(1, 3)) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_QUOTE) b ^= 8'h01;
					send_word(b, $urandom_range(0, 3) == 0);
				end
			end
		endcase
	endtask

	initial begin
		ledger = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray byte in idle, raw extremes, surrogate pair,
		// lone low surrogate, escaped zero, close, end of text while idle
		send_word(8'h41, 1'b0);
		send_word(CH_QUOTE, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_hex_escape(16'hD83D);
		send_hex_escape(16'hDE00);
		send_hex_escape(16'hDC00);
		send_hex_escape(16'h0000);
		send_word(CH_QUOTE, 1'b0);
		send_word(8'hA5, 1'b1);

		// random strings, every ending once first, then mostly well formed
		for (int s = 0; s < END_KINDS || n_sent < 190; s++) begin
			if (s == 5) begin
				// let the result side drain completely
				push <= 1'b0;
				@(posedge clk);
				while (ledger.words.size() != 0) @(posedge clk);
			end
			if (s < END_KINDS) send_string(ending_t'(s));
			else if ($urandom_range(0, 19) < 12) send_string(END_CLOSE);
			else send_string(ending_t'($urandom_range(1, END_KINDS - 1)));
		end

		push <= 1'b0;
		while (ledger.words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (ledger.fails == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
